@@ hw/rtl/ipv6p_pkg.sv @@
// Package for the IPv6 text address parser: beat types, parser state and the per-byte step.
`timescale 1ns / 1ps
`default_nettype none

package ipv6p_pkg;

  localparam int NumGroups = 8;
  localparam logic [3:0] NumGroupsW = 4'd8;
  localparam logic [2:0] MaxDigits = 3'd4;
  localparam logic [8:0] SymColon = 9'h03A;
  localparam logic [8:0] SymEnd = 9'h100;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD_COLON,
    PH_HEAD_DIG,
    PH_HEAD_COLON,
    PH_TAIL_WAIT,
    PH_TAIL_DIG,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  consumed;
    logic [2:0]  group_index;
    logic [15:0] group_value;
    logic        run_last;
  } out_beat_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  head;
    logic [3:0]  tail;
    logic [2:0]  digits;
    logic [15:0] accum;
    logic [5:0]  bytes;
  } parse_state_t;

  // Result of one parser step: the new state and an optional group store write.
  typedef struct packed {
    parse_state_t st;
    logic         wr_en;
    logic [2:0]   wr_pos;
    logic [15:0]  wr_val;
  } step_t;

  localparam parse_state_t StateReset = '{
    phase:  PH_START,
    head:   4'd0,
    tail:   4'd0,
    digits: 3'd0,
    accum:  16'd0,
    bytes:  6'd0
  };

  // Returns {valid, value} for a hex digit in either case.
  function automatic logic [4:0] hex_decode(logic [8:0] sym);
    logic [4:0] r;
    r = 5'd0;
    if (sym >= 9'h030 && sym <= 9'h039) begin
      r = {1'b1, sym[3:0]};
    end else if ((sym >= 9'h061 && sym <= 9'h066) || (sym >= 9'h041 && sym <= 9'h046)) begin
      r = {1'b1, sym[3:0] + 4'd9};
    end
    return r;
  endfunction

  // One step of the parser on a byte or on the end-of-string symbol.
  function automatic step_t parse_step(parse_state_t s, logic [8:0] sym);
    step_t      r;
    logic [4:0] hx;
    logic       hv;
    logic       colon;
    logic [3:0] used;
    hx = hex_decode(sym);
    hv = hx[4];
    colon = (sym == SymColon);
    used = s.head + s.tail;
    r.st = s;
    r.wr_en = 1'b0;
    r.wr_pos = used[2:0];
    r.wr_val = s.accum;
    case (s.phase)
      PH_START: begin
        if (colon) begin
          r.st.bytes = s.bytes + 6'd1;
          r.st.phase = PH_LEAD_COLON;
        end else if (hv) begin
          r.st.accum = {12'd0, hx[3:0]};
          r.st.digits = 3'd1;
          r.st.bytes = s.bytes + 6'd1;
          r.st.phase = PH_HEAD_DIG;
        end else begin
          r.st.phase = PH_ERROR;
        end
      end
      PH_LEAD_COLON: begin
        if (colon) begin
          r.st.bytes = s.bytes + 6'd1;
          r.st.phase = PH_TAIL_WAIT;
        end else begin
          r.st.phase = PH_ERROR;
        end
      end
      PH_HEAD_DIG: begin
        if (hv && s.digits < MaxDigits) begin
          r.st.accum = {s.accum[11:0], hx[3:0]};
          r.st.digits = s.digits + 3'd1;
          r.st.bytes = s.bytes + 6'd1;
        end else begin
          r.wr_en = 1'b1;
          r.st.head = s.head + 4'd1;
          if (s.head + 4'd1 >= NumGroupsW) begin
            r.st.phase = PH_DONE;
          end else if (colon) begin
            r.st.bytes = s.bytes + 6'd1;
            r.st.phase = PH_HEAD_COLON;
          end else begin
            r.st.phase = PH_ERROR;
          end
        end
      end
      PH_HEAD_COLON: begin
        if (colon) begin
          r.st.bytes = s.bytes + 6'd1;
          r.st.phase = PH_TAIL_WAIT;
        end else if (hv) begin
          r.st.accum = {12'd0, hx[3:0]};
          r.st.digits = 3'd1;
          r.st.bytes = s.bytes + 6'd1;
          r.st.phase = PH_HEAD_DIG;
        end else begin
          r.st.phase = PH_ERROR;
        end
      end
      PH_TAIL_WAIT: begin
        if (hv) begin
          r.st.accum = {12'd0, hx[3:0]};
          r.st.digits = 3'd1;
          r.st.bytes = s.bytes + 6'd1;
          r.st.phase = PH_TAIL_DIG;
        end else begin
          r.st.phase = PH_DONE;
        end
      end
      PH_TAIL_DIG: begin
        if (hv && s.digits < MaxDigits) begin
          r.st.accum = {s.accum[11:0], hx[3:0]};
          r.st.digits = s.digits + 3'd1;
          r.st.bytes = s.bytes + 6'd1;
        end else begin
          r.wr_en = 1'b1;
          r.st.tail = s.tail + 4'd1;
          if (used + 4'd1 >= NumGroupsW) begin
            r.st.phase = PH_DONE;
          end else if (colon) begin
            r.st.bytes = s.bytes + 6'd1;
            r.st.phase = PH_TAIL_WAIT;
          end else begin
            r.st.phase = PH_DONE;
          end
        end
      end
      default: begin
        r.st = s;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ipv6_text_address_parser_core.sv @@
// Top level of the IPv6 text address parser: per-byte parser and result buffer.
// Latency: the first result beat is valid the cycle after the last byte is accepted.
// Throughput: one text byte per cycle; each string gives eight beats, or one on error.
// A last byte waits only while the previous string's beats are still draining.
// Reset returns the parser to the start of a string and empties the result buffer;
// the group store and the buffered payload are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_text_address_parser_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ipv6p_pkg::in_beat_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ipv6p_pkg::out_beat_t      out_data_o
);
  import ipv6p_pkg::*;

  parse_state_t st_q, st_d;
  logic [15:0]  grp_q [NumGroups];
  logic [15:0]  fin_grp [NumGroups];

  logic [15:0]  obuf_q [NumGroups];
  logic [3:0]   out_h_q, out_t_q;
  logic [5:0]   out_bytes_q;
  logic         out_err_q;
  logic [2:0]   out_idx_q;
  logic         busy_q;

  step_t        step1, step2;
  logic         in_fire, out_fire, final_fire, out_final, out_free;

  // Two parser steps: the byte itself, then the end of string on a last byte.
  always_comb begin
    step1 = parse_step(st_q, {1'b0, in_data_i.char_byte});
    step2 = parse_step(step1.st, SymEnd);
  end

  // Input handshake; a last byte needs the result buffer to be free.
  assign out_final  = out_err_q || (out_idx_q == 3'(NumGroups - 1));
  assign out_fire   = out_valid_o && out_ready_i;
  assign out_free   = !busy_q || (out_ready_i && out_final);
  assign in_ready_o = !in_data_i.is_last || out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign final_fire = in_fire && in_data_i.is_last;

  // Parser state: restart after the last byte.
  always_comb begin
    st_d = st_q;
    if (in_fire) begin
      st_d = in_data_i.is_last ? StateReset : step1.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

  // Group store writes for bytes within a string.
  always_ff @(posedge clk_i) begin
    if (in_fire && step1.wr_en) begin
      grp_q[step1.wr_pos] <= step1.wr_val;
    end
  end

  // Group store as it stands after both steps of a last byte.
  always_comb begin
    fin_grp = grp_q;
    if (step1.wr_en) begin
      fin_grp[step1.wr_pos] = step1.wr_val;
    end
    if (step2.wr_en) begin
      fin_grp[step2.wr_pos] = step2.wr_val;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk_i) begin
    if (final_fire) begin
      obuf_q      <= fin_grp;
      out_h_q     <= step2.st.head;
      out_t_q     <= step2.st.tail;
      out_bytes_q <= step2.st.bytes;
      out_err_q   <= (step2.st.phase != PH_DONE);
    end
  end

  // Result buffer control: beat index and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_idx_q <= 3'd0;
    end else begin
      if (final_fire) begin
        busy_q    <= 1'b1;
        out_idx_q <= 3'd0;
      end else if (out_fire) begin
        if (out_final) begin
          busy_q <= 1'b0;
        end
        out_idx_q <= out_idx_q + 3'd1;
      end
    end
  end

  // Place head groups high, tail groups low, zeros between.
  logic [3:0]  idx_w, tail_end, src_sum;
  logic [15:0] grp_val;

  always_comb begin
    idx_w    = {1'b0, out_idx_q};
    tail_end = idx_w + out_t_q;
    src_sum  = out_h_q + tail_end;
    grp_val  = 16'd0;
    if (idx_w < out_h_q) begin
      grp_val = obuf_q[out_idx_q];
    end else if (tail_end >= NumGroupsW) begin
      grp_val = obuf_q[src_sum[2:0]];
    end
  end

  // Output beat.
  assign out_valid_o = busy_q;
  always_comb begin
    out_data_o.status      = out_err_q;
    out_data_o.consumed    = out_err_q ? 6'd0 : out_bytes_q;
    out_data_o.group_index = out_err_q ? 3'd0 : out_idx_q;
    out_data_o.group_value = out_err_q ? 16'd0 : grp_val;
    out_data_o.run_last    = out_final;
  end

endmodule

`default_nettype wire
